FILE: rtl/core/cfir_pkg.sv
// Shared definitions for the complex FIR filter core: opcodes, register
// widths and the control structs passed to the tap cells and the MAC unit.
// No dependencies.
package cfir_pkg;

  localparam int CFG_W      = 11;  // tap_count register width
  localparam int COEF_IDX_W = 10;  // coefficient load index width

  // input item opcodes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // per-cell controls
  typedef struct packed {
    logic samp_adv;  // take sample from neighbor
    logic coef_adv;  // take coefficient from neighbor
    logic coef_we;   // load coefficient from write port
  } cell_ctrl_t;

  // MAC controls
  typedef struct packed {
    logic clear;   // start of a new sum
    logic tap_en;  // current tap is inside tap_count
  } mac_ctrl_t;

endpackage

FILE: rtl/core/cfir_cell.sv
// One tap cell of the ring: holds one delayed sample and one coefficient
// and passes both to its neighbor on request. Depends on cfir_pkg.
module cfir_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfir_pkg::cell_ctrl_t          ctrl,
  input  logic signed [SAMPLE_BITS-1:0] samp_re_i,
  input  logic signed [SAMPLE_BITS-1:0] samp_im_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_re_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_im_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_wre,
  input  logic signed [SAMPLE_BITS-1:0] coef_wim,
  output logic signed [SAMPLE_BITS-1:0] samp_re_o,
  output logic signed [SAMPLE_BITS-1:0] samp_im_o,
  output logic signed [SAMPLE_BITS-1:0] coef_re_o,
  output logic signed [SAMPLE_BITS-1:0] coef_im_o
);

  logic signed [SAMPLE_BITS-1:0] samp_re_r, samp_im_r;
  logic signed [SAMPLE_BITS-1:0] coef_re_r, coef_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_re_r <= '0;
      samp_im_r <= '0;
      coef_re_r <= '0;
      coef_im_r <= '0;
    end else begin
      if (ctrl.samp_adv) begin
        samp_re_r <= samp_re_i;
        samp_im_r <= samp_im_i;
      end
      if (ctrl.coef_we) begin
        coef_re_r <= coef_wre;
        coef_im_r <= coef_wim;
      end else if (ctrl.coef_adv) begin
        coef_re_r <= coef_re_i;
        coef_im_r <= coef_im_i;
      end
    end
  end

  assign samp_re_o = samp_re_r;
  assign samp_im_o = samp_im_r;
  assign coef_re_o = coef_re_r;
  assign coef_im_o = coef_im_r;

endmodule

FILE: rtl/core/cfir_mac.sv
// Complex multiply-accumulate unit with rounding and saturation of the sum.
// Registered products, then a wide accumulator. Depends on cfir_pkg.
module cfir_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 44
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfir_pkg::mac_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sr,
  input  logic signed [SAMPLE_BITS-1:0] si,
  input  logic signed [SAMPLE_BITS-1:0] cr,
  input  logic signed [SAMPLE_BITS-1:0] ci,
  output logic signed [SAMPLE_BITS-1:0] res_re,
  output logic signed [SAMPLE_BITS-1:0] res_im,
  output logic                          clip
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (SAMPLE_BITS - 2);
  localparam logic signed [ACC_W-1:0] HI    = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO    = -HI - ACC_W'(1);

  logic signed [PW-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                    en_d1_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] rnd_re, rnd_im;
  logic                    clip_re, clip_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_d1_r <= 1'b0;
    end else begin
      en_d1_r <= ctrl.tap_en;
    end
  end

  always_ff @(posedge clk) begin
    p_rr_r <= PW'(sr) * PW'(cr);
    p_ii_r <= PW'(si) * PW'(ci);
    p_ri_r <= PW'(sr) * PW'(ci);
    p_ir_r <= PW'(si) * PW'(cr);
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (en_d1_r) begin
      acc_re_r <= acc_re_r + ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
      acc_im_r <= acc_im_r + ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    end
  end

  // round half up, floor shift back to Q1.x
  assign rnd_re = (acc_re_r + ROUND) >>> (SAMPLE_BITS - 1);
  assign rnd_im = (acc_im_r + ROUND) >>> (SAMPLE_BITS - 1);

  always_comb begin
    clip_re = 1'b1;
    clip_im = 1'b1;
    if (rnd_re > HI)      res_re = HI[SAMPLE_BITS-1:0];
    else if (rnd_re < LO) res_re = LO[SAMPLE_BITS-1:0];
    else begin
      res_re  = rnd_re[SAMPLE_BITS-1:0];
      clip_re = 1'b0;
    end
    if (rnd_im > HI)      res_im = HI[SAMPLE_BITS-1:0];
    else if (rnd_im < LO) res_im = LO[SAMPLE_BITS-1:0];
    else begin
      res_im  = rnd_im[SAMPLE_BITS-1:0];
      clip_im = 1'b0;
    end
  end

  assign clip = clip_re | clip_im;

endmodule

FILE: rtl/core/complex_fir_filter_core.sv
// Complex FIR filter core, top level: tap cell ring, complex MAC and the
// sequencer. Depends on cfir_pkg, cfir_cell and cfir_mac.
//
// Direct-form complex FIR over a ring of MAX_TAPS tap cells, each holding
// one delayed sample and its coefficient. A coefficient load (opcode 1)
// gives no result; loads at an index at or above MAX_TAPS are dropped.
// A sample (opcode 0) is shifted into the delay line on its transfer; the
// ring then rotates once around, feeding the last cell into a single
// complex MAC that sums the first tap_count taps (tap_count above MAX_TAPS
// counts as MAX_TAPS, zero gives a zero result). A drain state and a
// finish state (round, shift right by SAMPLE_BITS-1, saturate) follow
// before the next item is taken; the ring rotation through the one MAC
// sets how long a sample occupies the core. The finished result sits in
// an output register, so the next item can be taken while it waits; a
// result still stalled when the next one is done holds the core in its
// finish state. Reset clears delay line, coefficients and tap_count (to
// 1). The user must write tap_count via cfg_we/cfg_wdata only while the
// core is idle; the core itself does not enforce this.
module complex_fir_filter_core #(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_im,
  input  logic                                in_block_end,
  input  logic [cfir_pkg::COEF_IDX_W-1:0]     in_coef_index,
  input  logic signed [SAMPLE_BITS-1:0]       in_coef_re,
  input  logic signed [SAMPLE_BITS-1:0]       in_coef_im,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_re,
  output logic signed [SAMPLE_BITS-1:0]       out_im,
  output logic                                out_block_end,
  output logic                                out_saturated,
  // configuration
  input  logic                                cfg_we,
  input  logic [cfir_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int LW    = (TW > cfir_pkg::CFG_W) ? TW : cfir_pkg::CFG_W;
  localparam int IW    = (CNT_W > cfir_pkg::COEF_IDX_W) ? CNT_W : cfir_pkg::COEF_IDX_W;
  localparam int ACC_W = 2 * SAMPLE_BITS + 2 + CNT_W;
  localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,    // ring rotation, one tap per cycle into the MAC
    ST_DRAIN,  // last product enters the accumulator
    ST_FIN     // round/saturate into the output register
  } state_t;

  state_t                         state_r;
  logic [CNT_W-1:0]               cnt_r;        // ring index at the last cell
  logic [LW-1:0]                  n_r;          // clamped tap count for this sample
  logic [cfir_pkg::CFG_W-1:0]     tap_count_r;
  logic                           be_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_re_r, out_im_r;
  logic                           out_be_r, out_sat_r;

  logic                           sample_xfer, load_xfer, ring_adv, out_free;
  logic [LW-1:0]                  tc_clamped;
  logic [IW-1:0]                  coef_idx_ext;
  cfir_pkg::mac_ctrl_t            mac_ctrl;
  logic signed [SAMPLE_BITS-1:0]  res_re, res_im;
  logic                           res_clip;
  logic signed [SAMPLE_BITS-1:0]  head_re, head_im;

  // cell outputs, each read at its own fixed place in the chain
  logic signed [SAMPLE_BITS-1:0]  samp_re_w [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]  samp_im_w [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]  coef_re_w [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]  coef_im_w [MAX_TAPS];

  // ---------------------------------------------------------------------------
  // handshake and control decode
  // ---------------------------------------------------------------------------
  assign in_stall    = !rst_n || (state_r != ST_IDLE);
  assign sample_xfer = in_valid && !in_stall && (in_opcode == cfir_pkg::OP_FILTER);
  assign load_xfer   = in_valid && !in_stall && (in_opcode == cfir_pkg::OP_LOAD);
  assign ring_adv    = (state_r == ST_RUN);
  assign out_free    = !out_valid_r || !out_stall;

  assign tc_clamped   = (LW'(tap_count_r) > LW'(MAX_TAPS)) ? LW'(MAX_TAPS) : LW'(tap_count_r);
  assign coef_idx_ext = IW'(in_coef_index);

  // Cell 0 takes the new sample on a sample transfer and closes the ring
  // (takes the last cell) while rotating. Coefficients only rotate.
  assign head_re = ring_adv ? samp_re_w[MAX_TAPS-1] : in_sample_re;
  assign head_im = ring_adv ? samp_im_w[MAX_TAPS-1] : in_sample_im;

  // ---------------------------------------------------------------------------
  // tap cell ring
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    cfir_pkg::cell_ctrl_t          ctrl;
    logic signed [SAMPLE_BITS-1:0] s_re_in, s_im_in, c_re_in, c_im_in;

    assign ctrl.samp_adv = sample_xfer || ring_adv;
    assign ctrl.coef_adv = ring_adv;
    assign ctrl.coef_we  = load_xfer && (coef_idx_ext == IW'(i));

    if (i == 0) begin : g_head
      assign s_re_in = head_re;
      assign s_im_in = head_im;
      assign c_re_in = coef_re_w[MAX_TAPS-1];
      assign c_im_in = coef_im_w[MAX_TAPS-1];
    end else begin : g_body
      assign s_re_in = samp_re_w[i-1];
      assign s_im_in = samp_im_w[i-1];
      assign c_re_in = coef_re_w[i-1];
      assign c_im_in = coef_im_w[i-1];
    end

    cfir_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .samp_re_i (s_re_in),
      .samp_im_i (s_im_in),
      .coef_re_i (c_re_in),
      .coef_im_i (c_im_in),
      .coef_wre  (in_coef_re),
      .coef_wim  (in_coef_im),
      .samp_re_o (samp_re_w[i]),
      .samp_im_o (samp_im_w[i]),
      .coef_re_o (coef_re_w[i]),
      .coef_im_o (coef_im_w[i])
    );
  end

  // ---------------------------------------------------------------------------
  // MAC: the last cell holds tap index cnt_r during rotation, so a tap
  // counts when cnt_r < n_r. The ring is back home after MAX_TAPS steps.
  // ---------------------------------------------------------------------------
  assign mac_ctrl.clear  = sample_xfer;
  assign mac_ctrl.tap_en = ring_adv && (LW'(cnt_r) < n_r);

  cfir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .sr     (samp_re_w[MAX_TAPS-1]),
    .si     (samp_im_w[MAX_TAPS-1]),
    .cr     (coef_re_w[MAX_TAPS-1]),
    .ci     (coef_im_w[MAX_TAPS-1]),
    .res_re (res_re),
    .res_im (res_im),
    .clip   (res_clip)
  );

  // ---------------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tap_count_r <= cfir_pkg::CFG_W'(1);
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      // in the finish cycle the output register is handled below
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (sample_xfer) begin
            state_r <= ST_RUN;
            cnt_r   <= CNT_W'(MAX_TAPS - 1);
            n_r     <= tc_clamped;
            be_r    <= in_block_end;
          end
        end
        ST_RUN: begin
          if (cnt_r == '0) begin
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_re_r    <= res_re;
            out_im_r    <= res_im;
            out_be_r    <= be_r;
            out_sat_r   <= res_clip;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_re        = out_re_r;
  assign out_im        = out_im_r;
  assign out_block_end = out_be_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  // a sample transfer starts a full ring rotation
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    sample_xfer |=> (state_r == ST_RUN) && (cnt_r == CNT_W'(MAX_TAPS - 1)))
    else $error("sample transfer did not start rotation");

  // rotation ends exactly when the ring is back home
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == '0) |=> (state_r == ST_DRAIN))
    else $error("rotation did not end at index zero");

  // a waiting result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_valid_r && out_stall |=>
      $stable(out_re_r) && $stable(out_im_r) && (state_r == ST_FIN))
    else $error("pending result overwritten");

  // saturation flag implies a clipped part sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |->
      (out_re_r == SAT_HI) || (out_re_r == SAT_LO) ||
      (out_im_r == SAT_HI) || (out_im_r == SAT_LO))
    else $error("saturated flag without a value at a rail");
`endif

endmodule

FILE: tb/tb_top.sv
// Testbench for complex_fir_filter_core: a tracker class that predicts each
// filtered sample and checks result transfers, plus the top module that drives
// the block. Depends on cfir_pkg and the core RTL.
package cfir_tb_pkg;
  import cfir_pkg::*;

  localparam int     MAX_TAPS    = 1024;
  localparam int     SAMPLE_BITS = 16;
  localparam int     REPORT_MAX  = 10;
  localparam longint Q_MAX       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint Q_MIN       = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef logic signed [SAMPLE_BITS-1:0] q15_t;

  typedef struct {
    logic                  opcode;
    q15_t                  sample_re;
    q15_t                  sample_im;
    logic                  block_end;
    logic [COEF_IDX_W-1:0] coef_index;
    q15_t                  coef_re;
    q15_t                  coef_im;
  } fir_item_t;

  typedef struct {
    q15_t re;
    q15_t im;
    logic block_end;
    logic clipped;
  } fir_output_t;

  class cfir_tracker;
    q15_t             hist_re[MAX_TAPS];
    q15_t             hist_im[MAX_TAPS];
    q15_t             coef_re[MAX_TAPS];
    q15_t             coef_im[MAX_TAPS];
    logic [CFG_W-1:0] tap_count;
    fir_output_t      pending_outputs[$];
    int unsigned      mismatches;
    int unsigned      outputs_checked;

    function new();
      foreach (hist_re[k]) begin
        hist_re[k] = '0;
        hist_im[k] = '0;
        coef_re[k] = '0;
        coef_im[k] = '0;
      end
      tap_count       = CFG_W'(1);
      mismatches      = 0;
      outputs_checked = 0;
    endfunction

    function void set_tap_count(logic [CFG_W-1:0] value);
      tap_count = value;
    endfunction

    // add half an LSB, floor shift out the fraction, clip to the sample width
    function q15_t round_sat(longint acc, inout logic clip);
      longint r;
      r = (acc + (longint'(1) <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
      if (r > Q_MAX) begin
        r    = Q_MAX;
        clip = 1'b1;
      end else if (r < Q_MIN) begin
        r    = Q_MIN;
        clip = 1'b1;
      end
      return r[SAMPLE_BITS-1:0];
    endfunction

    // coefficient loads update the store; samples shift the whole line and
    // queue the expected filter output
    function void accept_item(fir_item_t it);
      fir_output_t exp_out;
      longint      acc_re;
      longint      acc_im;
      int unsigned n;
      logic        clip;
      if (it.opcode == OP_LOAD) begin
        if (int'(it.coef_index) < MAX_TAPS) begin
          coef_re[it.coef_index] = it.coef_re;
          coef_im[it.coef_index] = it.coef_im;
        end
        return;
      end
      for (int k = MAX_TAPS - 1; k > 0; k--) begin
        hist_re[k] = hist_re[k-1];
        hist_im[k] = hist_im[k-1];
      end
      hist_re[0] = it.sample_re;
      hist_im[0] = it.sample_im;
      n      = (int'(tap_count) > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
      acc_re = 0;
      acc_im = 0;
      clip   = 1'b0;
      for (int k = 0; k < n; k++) begin
        acc_re += longint'(hist_re[k]) * longint'(coef_re[k])
                - longint'(hist_im[k]) * longint'(coef_im[k]);
        acc_im += longint'(hist_re[k]) * longint'(coef_im[k])
                + longint'(hist_im[k]) * longint'(coef_re[k]);
      end
      exp_out.re        = round_sat(acc_re, clip);
      exp_out.im        = round_sat(acc_im, clip);
      exp_out.block_end = it.block_end;
      exp_out.clipped   = clip;
      pending_outputs.push_back(exp_out);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("MISMATCH %s", what);
    endfunction

    function void check_output(fir_output_t got);
      fir_output_t want;
      outputs_checked++;
      if (pending_outputs.size() == 0) begin
        flag($sformatf("result %0d with no sample waiting: re=%0d im=%0d end=%0b sat=%0b",
                       outputs_checked, got.re, got.im, got.block_end, got.clipped));
        return;
      end
      want = pending_outputs.pop_front();
      if (got.re !== want.re || got.im !== want.im ||
          got.block_end !== want.block_end || got.clipped !== want.clipped)
        flag($sformatf({"result %0d: expected re=%0d im=%0d end=%0b sat=%0b, ",
                        "got re=%0d im=%0d end=%0b sat=%0b"},
                       outputs_checked, want.re, want.im, want.block_end, want.clipped,
                       got.re, got.im, got.block_end, got.clipped));
    endfunction
  endclass

endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfir_pkg::*;
  import cfir_tb_pkg::*;

  localparam int     CLK_PERIOD    = 10;
  localparam int     RESET_CYCLES  = 6;
  // a sample holds the core for a full ring rotation plus drain and finish;
  // leave margin before touching tap_count
  localparam int     SETTLE_CYCLES = MAX_TAPS + 8;
  localparam int     SEGMENTS      = 9;
  localparam int     SEGMENT_ITEMS = 126;
  // ~1150 items; even all samples each holding the core for a full rotation,
  // plus gaps, stalls and settle waits stay well under this
  localparam longint CYCLE_LIMIT   = 6_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_opcode;
  q15_t                  in_sample_re;
  q15_t                  in_sample_im;
  logic                  in_block_end;
  logic [COEF_IDX_W-1:0] in_coef_index;
  q15_t                  in_coef_re;
  q15_t                  in_coef_im;
  logic                  out_valid;
  logic                  out_stall;
  q15_t                  out_re;
  q15_t                  out_im;
  logic                  out_block_end;
  logic                  out_saturated;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;

  cfir_tracker           fir_track;
  fir_output_t           seen_output;
  longint                cycle_count = 0;
  int unsigned           send_idle_pct = 6;   // chance per cycle the sender holds off
  int unsigned           recv_idle_pct = 82;  // chance per cycle the receiver stalls
  int unsigned           samples_sent = 0;
  int unsigned           loads_sent = 0;
  int unsigned           tap_writes = 0;

  complex_fir_filter_core #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .in_block_end (in_block_end),
    .in_coef_index(in_coef_index),
    .in_coef_re   (in_coef_re),
    .in_coef_im   (in_coef_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_re       (out_re),
    .out_im       (out_im),
    .out_block_end(out_block_end),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TIMEOUT after %0d cycles, %0d results still expected",
             cycle_count, fir_track.pending_outputs.size());
    $display("end of test: mismatches");
    $finish;
  end

  // result side back-pressure: redrawn every falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // a result transfer happens on a rising edge with valid high, stall low
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_output.re        = out_re;
      seen_output.im        = out_im;
      seen_output.block_end = out_block_end;
      seen_output.clipped   = out_saturated;
      fir_track.check_output(seen_output);
    end
  end

  // Present one item at a falling edge after a random hold-off, keep it
  // steady until the input transfer, then hand it to the tracker.
  task automatic send_item(fir_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_opcode     = it.opcode;
    in_sample_re  = it.sample_re;
    in_sample_im  = it.sample_im;
    in_block_end  = it.block_end;
    in_coef_index = it.coef_index;
    in_coef_re    = it.coef_re;
    in_coef_im    = it.coef_im;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    fir_track.accept_item(it);
    if (it.opcode == OP_LOAD)
      loads_sent++;
    else
      samples_sent++;
  endtask

  task automatic send_fields(logic op, int sre, int sim, logic be,
                             int idx, int cre, int cim);
    fir_item_t it;
    it.opcode     = op;
    it.sample_re  = q15_t'(sre);
    it.sample_im  = q15_t'(sim);
    it.block_end  = be;
    it.coef_index = COEF_IDX_W'(idx);
    it.coef_re    = q15_t'(cre);
    it.coef_im    = q15_t'(cim);
    send_item(it);
  endtask

  // Sender pauses until every expected result has arrived; a trailing load
  // can still be in flight, so the full sample latency is waited out too.
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (fir_track.pending_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // tap_count is only written with the core idle
  task automatic write_tap_count(int unsigned value);
    drain_and_settle();
    cfg_we    = 1'b1;
    cfg_wdata = value[CFG_W-1:0];
    @(posedge clk);
    fir_track.set_tap_count(cfg_wdata);
    tap_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly scaled-down values so long sums do not always clip; full scale
  // a quarter of the time
  function automatic q15_t shaped_q15();
    logic [31:0] raw;
    int unsigned sh;
    raw = $urandom;
    sh  = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
    return $signed(raw[SAMPLE_BITS-1:0]) >>> sh;
  endfunction

  // Loads mostly land inside the active taps so they shape the next
  // outputs; the rest go anywhere in the store.
  function automatic fir_item_t random_item(int unsigned span);
    fir_item_t it;
    it.opcode     = ($urandom_range(99) < 45) ? OP_LOAD : OP_FILTER;
    it.sample_re  = shaped_q15();
    it.sample_im  = shaped_q15();
    it.block_end  = ($urandom_range(3) == 0);
    it.coef_index = COEF_IDX_W'(($urandom_range(4) != 0) ? $urandom_range(span - 1)
                                                         : $urandom_range(MAX_TAPS - 1));
    it.coef_re    = shaped_q15();
    it.coef_im    = shaped_q15();
    return it;
  endfunction

  initial begin
    int unsigned tap_plan[SEGMENTS];
    int unsigned span;
    fir_track     = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_FILTER;
    in_sample_re  = '0;
    in_sample_im  = '0;
    in_block_end  = 1'b0;
    in_coef_index = '0;
    in_coef_re    = '0;
    in_coef_im    = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part, tap_count at its reset value of 1 ----
    // coefficient store cleared by reset: zero output, block end passed on
    send_fields(OP_FILTER, 100, -200, 1'b1, 5, 999, -999);
    // load most negative coefficient at tap 0; sample fields are ignored
    send_fields(OP_LOAD, 32767, 32767, 1'b1, 0, -32768, -32768);
    // (-1)*(-1-1j): both parts clip high
    send_fields(OP_FILTER, -32768, 0, 1'b0, 0, 0, 0);
    // real part cancels to zero, imaginary part clips low
    send_fields(OP_FILTER, 32767, 32767, 1'b1, 0, 0, 0);
    // coefficient of one half exercises rounding; coef fields of samples ignored
    send_fields(OP_LOAD, 0, 0, 1'b0, 0, 16384, 0);
    send_fields(OP_FILTER, 1, 0, 1'b0, 1023, 32767, 32767);
    send_fields(OP_FILTER, -1, 0, 1'b0, 1023, -32768, -32768);
    send_fields(OP_FILTER, 3, -3, 1'b1, 0, 0, 0);
    // top index of the store, then a small odd coefficient next to tap 0
    send_fields(OP_LOAD, -32768, -32768, 1'b0, 1023, 32767, -32768);
    send_fields(OP_LOAD, 0, 0, 1'b0, 1, -1, 1);

    // zero taps: empty sum, never clipped
    write_tap_count(0);
    send_fields(OP_FILTER, 32767, -32768, 1'b1, 0, 0, 0);
    send_fields(OP_LOAD, 0, 0, 1'b0, 2, 32767, 32767);
    send_fields(OP_FILTER, -32768, 32767, 1'b0, 0, 0, 0);

    // every tap in use, including the one at the top of the store
    write_tap_count(MAX_TAPS);
    send_fields(OP_FILTER, -32768, -32768, 1'b0, 0, 0, 0);
    send_fields(OP_FILTER, 12345, -23456, 1'b1, 0, 0, 0);

    // all ones: above MAX_TAPS, so capped to the full line
    write_tap_count(2047);
    send_fields(OP_FILTER, 32767, 32767, 1'b0, 0, 0, 0);
    send_fields(OP_LOAD, 0, 0, 1'b1, 3, -32768, 32767);
    send_fields(OP_FILTER, -7, 9, 1'b1, 0, 0, 0);

    // ---- random part: three segments per idle mode ----
    tap_plan = '{3, 1024, 17, 0, 2047, 64, 1, 700, 0};
    tap_plan[SEGMENTS-1] = $urandom_range(1100, 2);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_tap_count(tap_plan[seg]);
      span = (tap_plan[seg] == 0) ? 1
           : (tap_plan[seg] > MAX_TAPS) ? MAX_TAPS : tap_plan[seg];
      repeat (SEGMENT_ITEMS) send_item(random_item(span));
    end

    drain_and_settle();
    $display("Covered %0d samples and %0d coefficient loads across %0d tap_count writes,",
             samples_sent, loads_sent, tap_writes);
    $display("tap counts 0 to 2047, %0d results checked, %0d mismatches.",
             fir_track.outputs_checked, fir_track.mismatches);
    if (fir_track.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
